// ===== src/epwc_pkg.sv =====
// Shared types and constants for the echo pulse width capture block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package epwc_pkg;

  // Fixed field widths
  localparam int unsigned MASK_W = 4;
  localparam int unsigned TS_W   = 16;
  localparam int unsigned DUR_W  = 17;
  localparam int unsigned IRQ_W  = 4;

  // Wrap period after reset, in microseconds
  localparam logic [TS_W-1:0] WRAP_RESET = 16'd8738;

  // Register indexes on the configuration port
  localparam logic REG_MASK = 1'b0;
  localparam logic REG_WRAP = 1'b1;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_DISARM = 2'd1,
    CMD_EDGE   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_UNREG     = 3'd2,
    ST_NOT_READY = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  // One input word
  typedef struct packed {
    cmd_e             cmd;
    logic [IRQ_W-1:0] irq_number;
    logic             pin_level;
    logic [TS_W-1:0]  timestamp_us;
  } item_t;

  // One result word
  typedef struct packed {
    status_e          status;
    logic [DUR_W-1:0] echo_width;
  } result_t;

  // Configuration seen by the capture core
  typedef struct packed {
    logic [MASK_W-1:0] registered_mask;
    logic [TS_W-1:0]   wrap_period_us;
  } cfg_t;

endpackage

// ===== src/epwc_cfg_regs.sv =====
// APB-style configuration registers: channel registration mask and wrap period.
// Depends on epwc_pkg.
`timescale 1ns / 1ps

module epwc_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output epwc_pkg::cfg_t   cfg_o
);
  import epwc_pkg::*;

  logic [MASK_W-1:0] mask_q, mask_d;
  logic [TS_W-1:0]   wrap_q, wrap_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write decode on word address
  always_comb begin
    mask_d = mask_q;
    wrap_d = wrap_q;
    if (wr_en) begin
      if (paddr[2] == REG_MASK) begin
        mask_d = pwdata[MASK_W-1:0];
      end else begin
        wrap_d = pwdata[TS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      wrap_q <= WRAP_RESET;
    end else begin
      mask_q <= mask_d;
      wrap_q <= wrap_d;
    end
  end

  // Read back
  always_comb begin
    if (paddr[2] == REG_WRAP) begin
      prdata = {{(32-TS_W){1'b0}}, wrap_q};
    end else begin
      prdata = {{(32-MASK_W){1'b0}}, mask_q};
    end
  end

  assign cfg_o.registered_mask = mask_q;
  assign cfg_o.wrap_period_us  = wrap_q;

endmodule

// ===== src/epwc_core.sv =====
// Per-channel capture state and the result logic for one word.
// Depends on epwc_pkg.
`timescale 1ns / 1ps

module epwc_core #(
  parameter int unsigned CHANNELS  = 4,
  parameter int unsigned FIRST_IRQ = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              process_i,
  input  epwc_pkg::item_t   item_i,
  input  epwc_pkg::cfg_t    cfg_i,
  output epwc_pkg::result_t result_o
);
  import epwc_pkg::*;

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IRQ_W:0] FIRST_L = (IRQ_W+1)'(FIRST_IRQ);
  localparam logic [IRQ_W:0] CHAN_L  = (IRQ_W+1)'(CHANNELS);

  logic [CHANNELS-1:0] armed_q, armed_d;
  logic [CHANNELS-1:0] done_q, done_d;
  logic [TS_W-1:0]     rise_q [CHANNELS];
  logic [TS_W-1:0]     rise_d [CHANNELS];
  logic [TS_W-1:0]     fall_q [CHANNELS];
  logic [TS_W-1:0]     fall_d [CHANNELS];

  logic [IRQ_W:0]             irq_ext, irq_off;
  logic                       in_range;
  logic [CH_W-1:0]            ch_idx;
  logic [CHANNELS+MASK_W-1:0] mask_ext;
  logic [CHANNELS-1:0]        reg_vec;
  logic [DUR_W-1:0]           rise_x, fall_x, wrap_x, dur;

  // Line decode
  assign irq_ext  = {1'b0, item_i.irq_number};
  assign irq_off  = irq_ext - FIRST_L;
  assign in_range = (irq_ext >= FIRST_L) && (irq_off < CHAN_L);
  assign ch_idx   = irq_off[CH_W-1:0];

  // Channels past the mask width read as unregistered
  assign mask_ext = {{CHANNELS{1'b0}}, cfg_i.registered_mask};
  assign reg_vec  = mask_ext[CHANNELS-1:0];

  // Width, with the wrap period added when the counter has wrapped
  assign rise_x = {1'b0, rise_q[ch_idx]};
  assign fall_x = {1'b0, fall_q[ch_idx]};
  assign wrap_x = {1'b0, cfg_i.wrap_period_us};
  assign dur    = (fall_x >= rise_x) ? (fall_x - rise_x) : (fall_x + wrap_x - rise_x);

  // Command handling
  always_comb begin
    armed_d             = armed_q;
    done_d              = done_q;
    rise_d              = rise_q;
    fall_d              = fall_q;
    result_o.status     = ST_OK;
    result_o.echo_width = '0;
    if (!in_range) begin
      result_o.status = ST_INVALID;
    end else begin
      case (item_i.cmd)
        CMD_START, CMD_DISARM: begin
          if (!reg_vec[ch_idx]) begin
            result_o.status = ST_UNREG;
          end else begin
            done_d[ch_idx]  = 1'b0;
            armed_d[ch_idx] = (item_i.cmd == CMD_START);
          end
        end
        CMD_EDGE: begin
          if (armed_q[ch_idx]) begin
            if (item_i.pin_level) begin
              rise_d[ch_idx] = item_i.timestamp_us;
            end else begin
              fall_d[ch_idx]  = item_i.timestamp_us;
              done_d[ch_idx]  = 1'b1;
              armed_d[ch_idx] = 1'b0;
            end
          end
        end
        CMD_READ: begin
          if (!done_q[ch_idx]) begin
            result_o.status = ST_NOT_READY;
          end else begin
            result_o.echo_width = dur;
            if (dur > wrap_x) begin
              result_o.status = ST_RANGE;
            end
            done_d[ch_idx] = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // State commits only when the word moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      done_q  <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        rise_q[c] <= '0;
        fall_q[c] <= '0;
      end
    end else if (process_i) begin
      armed_q <= armed_d;
      done_q  <= done_d;
      rise_q  <= rise_d;
      fall_q  <= fall_d;
    end
  end

`ifndef ASSERT_OFF
  // A channel is never armed and done at once
  a_armed_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (armed_q & done_q) == '0)
    else $error("channel both armed and done");

  // Flags hold while no word is processed
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !process_i |=> $stable(armed_q) && $stable(done_q))
    else $error("flags changed without a word");

  // A bad line leaves every flag alone
  a_invalid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process_i && !in_range |=> $stable(armed_q) && $stable(done_q))
    else $error("flags changed on an invalid line");
`endif

endmodule

// ===== src/echo_pulse_width_capture.sv =====
// Top level of the echo pulse width capture block: input and result registers.
// Depends on epwc_pkg, epwc_cfg_regs and epwc_core.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                  payload
//  input     in         in_valid_i / in_stall_o    cmd, irq_number, pin_level, timestamp_us
//  result    out        out_valid_o / out_stall_i  status, echo_width
//  config    in         psel/penable/pwrite        paddr, pwdata, prdata (pready tied high)
//
//  One word per cycle while in_stall_o is low; a result is offered once its word has
//  passed the input register, then the result register, with the channel update in between.
//  Reset clears all channel flags and times, mask to zero, wrap period to 8738.
//  A stall on the result side holds the result; one further word waits in the
//  input register, after which in_stall_o is raised.

module echo_pulse_width_capture #(
  parameter int unsigned CHANNELS  = 4,
  parameter int unsigned FIRST_IRQ = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  irq_number_i,
  input  logic        pin_level_i,
  input  logic [15:0] timestamp_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [16:0] echo_width_o
);
  import epwc_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  result_t res, res_q;
  logic    s1_valid_q, s1_valid_d;
  logic    out_valid_q, out_valid_d;
  logic    out_ready, advance, accept;

  // Configuration port
  epwc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline handshake
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.cmd          <= cmd_e'(cmd_i);
      item_q.irq_number   <= irq_number_i;
      item_q.pin_level    <= pin_level_i;
      item_q.timestamp_us <= timestamp_us_i;
    end
  end

  // Channel state and result logic
  epwc_core #(
    .CHANNELS  (CHANNELS),
    .FIRST_IRQ (FIRST_IRQ)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .process_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .result_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_q.status;
  assign echo_width_o = res_q.echo_width;

endmodule

// ===== tb/sv/echo_pulse_width_capture_tb.sv =====
// Self-checking testbench for echo_pulse_width_capture: directed and random command words
// checked against an in-bench channel model. Depends on epwc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module echo_pulse_width_capture_tb;
  import epwc_pkg::*;

  localparam int unsigned CHANNELS  = 4;
  localparam int unsigned FIRST_IRQ = 8;
  localparam int unsigned WORD_GOAL = 550;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  cmd_i;
  logic [3:0]  irq_number_i;
  logic        pin_level_i;
  logic [15:0] timestamp_us_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [16:0] echo_width_o;

  echo_pulse_width_capture #(
    .CHANNELS (CHANNELS),
    .FIRST_IRQ(FIRST_IRQ)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .irq_number_i  (irq_number_i),
    .pin_level_i   (pin_level_i),
    .timestamp_us_i(timestamp_us_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .echo_width_o  (echo_width_o)
  );

  always #5 clk_i = ~clk_i;

  // Channel model state and its copy of the registers
  logic [MASK_W-1:0] model_mask;
  logic [TS_W-1:0]   model_wrap;
  logic              ch_armed [CHANNELS];
  logic              ch_done  [CHANNELS];
  logic [TS_W-1:0]   ch_rise  [CHANNELS];
  logic [TS_W-1:0]   ch_fall  [CHANNELS];

  result_t     pending_results[$];
  int unsigned errors;
  int unsigned words_sent;
  int unsigned results_checked;
  int unsigned status_count[5];
  int unsigned settings_used;
  bit          tx_calm;
  bit          rx_calm;
  int unsigned hold_left;

  // Most gaps short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 8);
    return $urandom_range(20, 50);
  endfunction

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Expected result of one word; updates the channel model
  function automatic result_t predict_capture(item_t w);
    result_t           r;
    int unsigned       ch;
    logic [DUR_W-1:0]  span;
    r.status     = ST_OK;
    r.echo_width = '0;
    if (w.irq_number < FIRST_IRQ || w.irq_number >= FIRST_IRQ + CHANNELS) begin
      r.status = ST_INVALID;
      return r;
    end
    ch = w.irq_number - FIRST_IRQ;
    case (w.cmd)
      CMD_START, CMD_DISARM: begin
        if (!model_mask[ch]) begin
          r.status = ST_UNREG;
        end else begin
          ch_done[ch]  = 1'b0;
          ch_armed[ch] = (w.cmd == CMD_START);
        end
      end
      CMD_EDGE: begin
        // edges count only while armed; no registration check
        if (ch_armed[ch]) begin
          if (w.pin_level) begin
            ch_rise[ch] = w.timestamp_us;
          end else begin
            ch_fall[ch]  = w.timestamp_us;
            ch_done[ch]  = 1'b1;
            ch_armed[ch] = 1'b0;
          end
        end
      end
      default: begin
        if (!ch_done[ch]) begin
          r.status = ST_NOT_READY;
        end else begin
          // timer wrapped when fall is below rise; 17-bit arithmetic wraps too
          if (ch_fall[ch] >= ch_rise[ch]) span = DUR_W'(ch_fall[ch]) - DUR_W'(ch_rise[ch]);
          else span = DUR_W'(ch_fall[ch]) + DUR_W'(model_wrap) - DUR_W'(ch_rise[ch]);
          if (span > DUR_W'(model_wrap)) r.status = ST_RANGE;
          r.echo_width = span;
          ch_done[ch]  = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  // Predict on every accepted word, check every accepted result
  always @(posedge clk_i) begin : scoreboard
    item_t   seen;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: status %0d echo_width %0d",
                 status_o, echo_width_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            errors++;
          end
          if (echo_width_o !== want.echo_width) begin
            $error("echo_width: expected %0d, actual %0d", want.echo_width, echo_width_o);
            errors++;
          end
          results_checked++;
          status_count[int'(want.status)]++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        seen.cmd          = cmd_e'(cmd_i);
        seen.irq_number   = irq_number_i;
        seen.pin_level    = pin_level_i;
        seen.timestamp_us = timestamp_us_i;
        pending_results.push_back(predict_capture(seen));
      end
    end
  end

  // Result side: random stalls, calm stretches and requested long holds
  initial begin : result_sink
    int unsigned run;
    run = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (run > 0) begin
        run--;
        out_stall_i <= 1'b1;
      end else if (rx_calm || $urandom_range(0, 3) != 0) begin
        out_stall_i <= 1'b0;
      end else begin
        run = pick_gap();
        out_stall_i <= (run > 0);
        if (run > 0) run--;
      end
    end
  end

  // Offer one word, hold it until taken; valid stays high for a following word
  task automatic send_word(cmd_e c, int unsigned irq, logic lvl, logic [15:0] ts);
    int unsigned gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= c;
    irq_number_i   <= 4'(irq);
    pin_level_i    <= lvl;
    timestamp_us_i <= ts;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_check(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_MASK && prdata[MASK_W-1:0] !== value[MASK_W-1:0]) begin
      $error("registered_mask: expected %0d, actual %0d", value[MASK_W-1:0],
             prdata[MASK_W-1:0]);
      errors++;
    end
    if (idx == REG_WRAP && prdata[TS_W-1:0] !== value[TS_W-1:0]) begin
      $error("wrap_period_us: expected %0d, actual %0d", value[TS_W-1:0], prdata[TS_W-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register (block idle), mirror it in the model, read it back
  task automatic cfg_set(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_MASK) model_mask = value[MASK_W-1:0];
    else model_wrap = value[TS_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    cfg_check(idx, value);
  endtask

  // One arm / rise / fall / read sequence on a random channel, with occasional detours
  task automatic run_measurement();
    int unsigned ch;
    int unsigned irq;
    logic [15:0] rise;
    logic [15:0] fall;
    ch   = $urandom_range(0, CHANNELS - 1);
    irq  = FIRST_IRQ + ch;
    rise = 16'($urandom);
    if (chance(20)) fall = 16'($urandom);
    else fall = rise + 16'($urandom_range(0, int'(model_wrap) + 32));
    send_word(CMD_START, irq, 1'($urandom), 16'($urandom));
    if (chance(15)) send_word(CMD_READ, irq, 1'($urandom), 16'($urandom));
    if (chance(10)) send_word(CMD_EDGE, irq, 1'b1, 16'($urandom));
    send_word(CMD_EDGE, irq, 1'b1, rise);
    if (chance(10)) send_word(CMD_DISARM, irq, 1'($urandom), 16'($urandom));
    send_word(CMD_EDGE, irq, 1'b0, fall);
    if (chance(10)) send_word(CMD_EDGE, irq, 1'($urandom), 16'($urandom));
    send_word(CMD_READ, irq, 1'($urandom), 16'($urandom));
    if (chance(10)) send_word(CMD_READ, irq, 1'($urandom), 16'($urandom));
  endtask

  task automatic send_noise();
    send_word(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 15), 1'($urandom),
              16'($urandom));
  endtask

  // Register values after reset, and commands on unregistered channels
  task automatic test_reset_state();
    cfg_check(REG_MASK, 32'd0);
    cfg_check(REG_WRAP, 32'(WRAP_RESET));
    send_word(CMD_START, FIRST_IRQ, 1'b0, 16'd0);
    send_word(CMD_DISARM, FIRST_IRQ + 3, 1'b1, 16'hFFFF);
    send_word(CMD_READ, FIRST_IRQ + 1, 1'b0, 16'd0);
    send_word(CMD_EDGE, FIRST_IRQ + 2, 1'b0, 16'd77);
    wait_idle();
  endtask

  // Every command, line limits, wrap and range cases
  task automatic test_directed_cases();
    cfg_set(REG_MASK, 32'b0111);
    settings_used++;
    // lines outside the channel range
    send_word(CMD_START, 0, 1'b0, 16'd0);
    send_word(CMD_EDGE, FIRST_IRQ - 1, 1'b1, 16'hFFFF);
    send_word(CMD_READ, FIRST_IRQ + CHANNELS, 1'b0, 16'd5);
    send_word(CMD_DISARM, 15, 1'b1, 16'd9);
    // widest span: beyond the wrap period
    send_word(CMD_START, FIRST_IRQ, 1'b0, 16'd0);
    send_word(CMD_EDGE, FIRST_IRQ, 1'b1, 16'd0);
    send_word(CMD_EDGE, FIRST_IRQ, 1'b0, 16'hFFFF);
    send_word(CMD_READ, FIRST_IRQ, 1'b0, 16'd0);
    // plain pulse, then a read with nothing captured
    send_word(CMD_START, FIRST_IRQ + 1, 1'b1, 16'd3);
    send_word(CMD_EDGE, FIRST_IRQ + 1, 1'b1, 16'd100);
    send_word(CMD_EDGE, FIRST_IRQ + 1, 1'b0, 16'd350);
    send_word(CMD_READ, FIRST_IRQ + 1, 1'b1, 16'd0);
    send_word(CMD_READ, FIRST_IRQ + 1, 1'b0, 16'd0);
    // timer wrapped between rise and fall
    send_word(CMD_START, FIRST_IRQ + 2, 1'b0, 16'd0);
    send_word(CMD_EDGE, FIRST_IRQ + 2, 1'b1, 16'd8000);
    send_word(CMD_EDGE, FIRST_IRQ + 2, 1'b0, 16'd100);
    send_word(CMD_READ, FIRST_IRQ + 2, 1'b0, 16'd0);
    // disarm drops the edge that follows
    send_word(CMD_START, FIRST_IRQ + 2, 1'b0, 16'd0);
    send_word(CMD_DISARM, FIRST_IRQ + 2, 1'b0, 16'd0);
    send_word(CMD_EDGE, FIRST_IRQ + 2, 1'b0, 16'd40);
    send_word(CMD_READ, FIRST_IRQ + 2, 1'b0, 16'd0);
    // unregistered channel: start refused, edge ignored, read not ready
    send_word(CMD_START, FIRST_IRQ + 3, 1'b0, 16'd0);
    send_word(CMD_EDGE, FIRST_IRQ + 3, 1'b0, 16'd12);
    send_word(CMD_READ, FIRST_IRQ + 3, 1'b0, 16'd0);
    wait_idle();
  endtask

  // Receiver holds off long while words keep coming, so the input stalls
  task automatic test_backpressure();
    cfg_set(REG_MASK, 32'hF);
    settings_used++;
    tx_calm   = 1'b1;
    hold_left = 60;
    repeat (3) run_measurement();
    tx_calm = 1'b0;
    wait_idle();
  endtask

  // Random sequences under a series of register settings, extremes included
  task automatic test_register_phases();
    logic [3:0]  masks[7];
    logic [15:0] wraps[7];
    int unsigned phase_end;
    masks = '{4'hF, 4'hF, 4'b0101, 4'hF, 4'h0, 4'b1010, 4'hF};
    wraps = '{16'd8738, 16'hFFFF, 16'd1, 16'd0, 16'd300, 16'd2000, 16'd8738};
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      cfg_set(REG_MASK, 32'(masks[p]));
      cfg_set(REG_WRAP, 32'(wraps[p]));
      settings_used++;
      // one phase runs with no idling on either side
      tx_calm   = (p == 2);
      rx_calm   = (p == 2);
      phase_end = (p == 6) ? WORD_GOAL : words_sent + 70;
      while (words_sent < phase_end) begin
        if (chance(80)) run_measurement();
        else send_noise();
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin : timeout_guard
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main_sequence
    int unsigned drain;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_valid_i     <= 1'b0;
    cmd_i          <= CMD_START;
    irq_number_i   <= '0;
    pin_level_i    <= 1'b0;
    timestamp_us_i <= '0;
    errors          = 0;
    words_sent      = 0;
    results_checked = 0;
    settings_used   = 1;
    tx_calm         = 1'b0;
    rx_calm         = 1'b0;
    hold_left       = 0;
    foreach (status_count[i]) status_count[i] = 0;
    model_mask = '0;
    model_wrap = WRAP_RESET;
    for (int c = 0; c < CHANNELS; c++) begin
      ch_armed[c] = 1'b0;
      ch_done[c]  = 1'b0;
      ch_rise[c]  = '0;
      ch_fall[c]  = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed_cases();
    test_backpressure();
    test_register_phases();

    // Drain, once the last word has been recorded, then allow for the latency
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    drain = 0;
    while (pending_results.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end

    $display("Ran %0d command words under %0d register settings; %0d results checked.",
             words_sent, settings_used, results_checked);
    $display("Results by status: ok %0d, bad line %0d, unregistered %0d, not ready %0d, range %0d.",
             status_count[0], status_count[1], status_count[2], status_count[3],
             status_count[4]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== echo_pulse_width_capture.f =====
src/epwc_pkg.sv
src/epwc_cfg_regs.sv
src/epwc_core.sv
src/echo_pulse_width_capture.sv
tb/sv/echo_pulse_width_capture_tb.sv
